FILE: sv/lev_pkg.sv
// shared constants and types for the edit distance engine
`default_nettype none

package lev_pkg;

	localparam int SYM_W  = 8;
	localparam int CMD_W  = 2;
	localparam int DIST_W = 7;

	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TARGET = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

	// target byte travelling along the row of cells
	typedef struct packed {
		logic             vld;
		logic [SYM_W-1:0] sym;
	} lev_beat_t;

endpackage

`default_nettype wire

FILE: sv/levenshtein_distance.sv
// levenshtein_distance: query and target bytes are taken one beat per cycle.
// each target byte walks the whole cell row one cell per cycle, so a finish beat
// waits until the last target byte has left the row and no earlier result is
// held by result_stall, then the result is registered and shown the next cycle.
// async reset and every finish beat clear lengths, error and the score row.
`default_nettype none

module levenshtein_distance
	import lev_pkg::*;
#(
	parameter int MAX_LEN = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire logic [CMD_W-1:0]  cmd,
	input  wire logic [SYM_W-1:0]  symbol,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic [DIST_W-1:0]      distance,
	output logic                   error
);

	localparam int SW = $clog2(MAX_LEN + 1);
	localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam logic [SW-1:0] MAX_CNT = SW'(MAX_LEN);

	logic [SW-1:0] qlen_q, tlen_q;
	logic          tstarted_q, err_q;

	lev_beat_t        beat_s1;
	logic             tgt_vld_s1;
	logic [SYM_W-1:0] tgt_sym_s1;
	logic [SW-1:0]    left_s1, diag_s1;

	lev_beat_t     link_beat [MAX_LEN];
	logic [SW-1:0] link_left [MAX_LEN];
	logic [SW-1:0] link_diag [MAX_LEN];
	logic [SW-1:0] cell_score[MAX_LEN];
	logic [MAX_LEN-1:0] link_vld;

	logic          accept, do_query, do_target, do_finish, busy;
	logic [SW-1:0] qlen_m1, sel_score;
	logic [SW+DIST_W-1:0] dist_ext;

	logic                result_valid_q, error_q;
	logic [DIST_W-1:0]   distance_q;

	assign busy   = beat_s1.vld | (|link_vld);
	assign accept = item_valid && !item_stall;

	always_comb begin
		item_stall = 1'b0;
		if (item_valid && cmd == CMD_FINISH) begin
			item_stall = busy || (result_valid_q && result_stall);
		end
	end

	assign do_query  = accept && cmd == CMD_QUERY && !err_q && !tstarted_q
		&& qlen_q != MAX_CNT;
	assign do_target = accept && cmd == CMD_TARGET && !err_q && tlen_q != MAX_CNT;
	assign do_finish = accept && cmd == CMD_FINISH;

	// length and error bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q     <= '0;
			tlen_q     <= '0;
			tstarted_q <= 1'b0;
			err_q      <= 1'b0;
			tgt_vld_s1 <= 1'b0;
		end else if (do_finish) begin
			qlen_q     <= '0;
			tlen_q     <= '0;
			tstarted_q <= 1'b0;
			err_q      <= 1'b0;
			tgt_vld_s1 <= 1'b0;
		end else begin
			tgt_vld_s1 <= do_target;
			if (do_query) begin
				qlen_q <= qlen_q + 1'b1;
			end
			if (do_target) begin
				tlen_q     <= tlen_q + 1'b1;
				tstarted_q <= 1'b1;
			end
			if (accept && !err_q) begin
				if (cmd == CMD_QUERY && (tstarted_q || qlen_q == MAX_CNT)) begin
					err_q <= 1'b1;
				end
				if (cmd == CMD_TARGET && tlen_q == MAX_CNT) begin
					err_q <= 1'b1;
				end
			end
		end
	end

	// boundary column: new row 0 is the target count, diagonal the old count
	always_ff @(posedge clk) begin
		tgt_sym_s1 <= symbol;
		left_s1    <= tlen_q + 1'b1;
		diag_s1    <= tlen_q;
	end

	assign beat_s1.vld = tgt_vld_s1;
	assign beat_s1.sym = tgt_sym_s1;

	generate
		for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
			localparam logic [SW-1:0] J = SW'(j);
			lev_beat_t     b_in;
			logic [SW-1:0] l_in, d_in;
			if (j == 0) begin : g_first
				assign b_in = beat_s1;
				assign l_in = left_s1;
				assign d_in = diag_s1;
			end else begin : g_rest
				assign b_in = link_beat[j-1];
				assign l_in = link_left[j-1];
				assign d_in = link_diag[j-1];
			end
			lev_cell #(
				.SW  (SW),
				.IDX (j)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.clr      (do_finish),
				.q_we     (do_query && qlen_q == J),
				.q_sym    (symbol),
				.beat_in  (b_in),
				.left_in  (l_in),
				.diag_in  (d_in),
				.beat_out (link_beat[j]),
				.left_out (link_left[j]),
				.diag_out (link_diag[j]),
				.score    (cell_score[j])
			);
			assign link_vld[j] = link_beat[j].vld;
		end
	endgenerate

	// score at the query length; an empty query reads the target count
	assign qlen_m1   = qlen_q - 1'b1;
	assign sel_score = (qlen_q == '0) ? tlen_q : cell_score[qlen_m1[IW-1:0]];
	assign dist_ext  = {{DIST_W{1'b0}}, sel_score};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (do_finish) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_finish) begin
			distance_q <= err_q ? '0 : dist_ext[DIST_W-1:0];
			error_q    <= err_q;
		end
	end

	assign result_valid = result_valid_q;
	assign distance     = distance_q;
	assign error        = error_q;

endmodule

`default_nettype wire

FILE: sv/lev_cell.sv
// one cell of the systolic row: holds one query byte and one score entry
`default_nettype none

module lev_cell
	import lev_pkg::*;
#(
	parameter int SW  = 7,
	parameter int IDX = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clr,
	input  wire logic             q_we,
	input  wire logic [SYM_W-1:0] q_sym,
	input  wire lev_beat_t        beat_in,
	input  wire logic [SW-1:0]    left_in,
	input  wire logic [SW-1:0]    diag_in,
	output lev_beat_t             beat_out,
	output logic [SW-1:0]         left_out,
	output logic [SW-1:0]         diag_out,
	output logic [SW-1:0]         score
);

	localparam logic [SW-1:0] INIT = SW'(IDX + 1);

	logic [SYM_W-1:0] qsym_q;
	logic [SW-1:0]    score_q;
	logic             vld_q;
	logic [SYM_W-1:0] sym_q;
	logic [SW-1:0]    new_q;
	logic [SW-1:0]    old_q;

	logic [SW:0] up_c, left_c, diag_c, min_ab, min_all;

	always_comb begin
		up_c    = {1'b0, score_q} + 1'b1;
		left_c  = {1'b0, left_in} + 1'b1;
		diag_c  = {1'b0, diag_in} + {{SW{1'b0}}, (qsym_q != beat_in.sym)};
		min_ab  = (up_c < left_c) ? up_c : left_c;
		min_all = (min_ab < diag_c) ? min_ab : diag_c;
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			qsym_q <= q_sym;
		end
		sym_q <= beat_in.sym;
		new_q <= min_all[SW-1:0];
		old_q <= score_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= INIT;
			vld_q   <= 1'b0;
		end else if (clr) begin
			score_q <= INIT;
			vld_q   <= 1'b0;
		end else begin
			vld_q <= beat_in.vld;
			if (beat_in.vld) begin
				score_q <= min_all[SW-1:0];
			end
		end
	end

	assign beat_out.vld = vld_q;
	assign beat_out.sym = sym_q;
	assign left_out     = new_q;
	assign diag_out     = old_q;
	assign score        = score_q;

endmodule

`default_nettype wire
